### rtl/bpra_pkg.sv
// Shared types, constants and codes of the bitmap page run allocator.
package bpra_pkg;

  localparam int ADDR_W           = 48;
  localparam int CNT_W            = 13;
  localparam int FUNC_W           = 2;
  localparam int NUM_REGIONS      = 2;
  localparam int REG_W            = 1;
  localparam int PAGE_SHIFT       = 12;
  localparam int PAGE_BYTES       = 4096;
  localparam int BM_W             = 64;
  localparam int REGION_PAGES_DEF = 4096;
  localparam int BM_DEPTH_DEF     = NUM_REGIONS * ((REGION_PAGES_DEF + BM_W - 1) / BM_W);
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 48;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_MARK  = 2'd1,
    FUNC_FREE  = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_0  = 2'd0,
    CFG_PAGES_0 = 2'd1,
    CFG_BASE_1  = 2'd2,
    CFG_PAGES_1 = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_FULL,
    EV_FREE_HIT,
    EV_FREE_PASS,
    EV_MIXED
  } ev_kind_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] start_address;
    logic [CNT_W-1:0]  page_count;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] run_address;
    logic              failed;
  } out_word_t;

  typedef struct packed {
    logic take;
    logic set_fail;
    logic next_reg;
    logic rd_first;
    logic rd_next;
    logic ev_step;
    logic ch_step;
    logic hit_setup;
    logic am_rd;
    logic am_wr;
    logic mw_next;
    logic mk_step;
    logic fl_rd;
    logic fl_wr;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              cnt_zero;
    logic              reg_empty;
    logic              reg_last;
    ev_kind_t          ev_kind;
    logic              word_last;
    logic              ch_hit;
    logic              chunk_last;
    logic              am_last;
    logic              rem_zero;
    logic              pg_hit;
    logic              pend_v;
    logic              pend_same;
    logic              out_busy;
  } dp_stat_t;

endpackage

### rtl/bpra_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bpra_ram #(
  parameter int WIDTH = bpra_pkg::BM_W,
  parameter int DEPTH = bpra_pkg::BM_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/bpra_ctrl.sv
// Controller state machine that sequences allocation scans and range marking.
module bpra_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bpra_pkg::dp_stat_t    stat,
  output bpra_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_REG,
    S_EVAL,
    S_CHUNK,
    S_HIT,
    S_AM_RD,
    S_AM_WR,
    S_MK_PAGE,
    S_FL_RD,
    S_FL_WR,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.func) inside
          bpra_pkg::FUNC_ALLOC: begin
            if (stat.cnt_zero) begin
              cmd.set_fail = 1'b1;
              state_nxt    = S_DONE;
            end else begin
              state_nxt = S_REG;
            end
          end
          bpra_pkg::FUNC_MARK, bpra_pkg::FUNC_FREE: begin
            state_nxt = S_MK_PAGE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_REG: begin
        if (stat.reg_empty) begin
          if (stat.reg_last) begin
            cmd.set_fail = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            cmd.next_reg = 1'b1;
          end
        end else begin
          cmd.rd_first = 1'b1;
          state_nxt    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.ev_step = 1'b1;
        unique case (stat.ev_kind)
          bpra_pkg::EV_FREE_HIT: begin
            state_nxt = S_HIT;
          end
          bpra_pkg::EV_MIXED: begin
            state_nxt = S_CHUNK;
          end
          default: begin
            if (stat.word_last) begin
              if (stat.reg_last) begin
                cmd.set_fail = 1'b1;
                state_nxt    = S_DONE;
              end else begin
                cmd.next_reg = 1'b1;
                state_nxt    = S_REG;
              end
            end else begin
              cmd.rd_next = 1'b1;
            end
          end
        endcase
      end
      S_CHUNK: begin
        cmd.ch_step = 1'b1;
        if (stat.ch_hit) begin
          state_nxt = S_HIT;
        end else if (stat.chunk_last) begin
          if (stat.word_last) begin
            if (stat.reg_last) begin
              cmd.set_fail = 1'b1;
              state_nxt    = S_DONE;
            end else begin
              cmd.next_reg = 1'b1;
              state_nxt    = S_REG;
            end
          end else begin
            cmd.rd_next = 1'b1;
            state_nxt   = S_EVAL;
          end
        end
      end
      S_HIT: begin
        cmd.hit_setup = 1'b1;
        state_nxt     = S_AM_RD;
      end
      S_AM_RD: begin
        cmd.am_rd = 1'b1;
        state_nxt = S_AM_WR;
      end
      S_AM_WR: begin
        cmd.am_wr = 1'b1;
        if (stat.am_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.mw_next = 1'b1;
          state_nxt   = S_AM_RD;
        end
      end
      S_MK_PAGE: begin
        if (stat.rem_zero) begin
          state_nxt = stat.pend_v ? S_FL_RD : S_DONE;
        end else if (stat.pg_hit && stat.pend_v && !stat.pend_same) begin
          state_nxt = S_FL_RD;
        end else begin
          cmd.mk_step = 1'b1;
        end
      end
      S_FL_RD: begin
        cmd.fl_rd = 1'b1;
        state_nxt = S_FL_WR;
      end
      S_FL_WR: begin
        cmd.fl_wr = 1'b1;
        state_nxt = S_MK_PAGE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/bpra_dp.sv
// Datapath: region registers, used-page bitmap, run search and range marking.
module bpra_dp #(
  parameter int REGION_PAGES = bpra_pkg::REGION_PAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bpra_pkg::in_word_t                  in_word,
  input  logic                                cfg_valid,
  input  logic [bpra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpra_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output bpra_pkg::out_word_t                 out_word,
  input  bpra_pkg::ctrl_cmd_t                 cmd,
  output bpra_pkg::dp_stat_t                  stat
);

  localparam int ADDR_W = bpra_pkg::ADDR_W;
  localparam int CNT_W  = bpra_pkg::CNT_W;
  localparam int BM_W   = bpra_pkg::BM_W;
  localparam int NREG   = bpra_pkg::NUM_REGIONS;
  localparam int REG_W  = bpra_pkg::REG_W;
  localparam int PSH    = bpra_pkg::PAGE_SHIFT;
  localparam int WPR    = (REGION_PAGES + BM_W - 1) / BM_W;
  localparam int DEPTH  = NREG * WPR;
  localparam int AW     = $clog2(DEPTH);
  localparam int PI_W   = $clog2(REGION_PAGES);
  localparam int WI_W   = (PI_W > 6) ? PI_W - 6 : 1;
  localparam int NP_W   = (PI_W + 1 > CNT_W) ? PI_W + 1 : CNT_W;
  localparam int CW     = ((PI_W > CNT_W) ? PI_W : CNT_W) + 1;
  localparam int A1_W   = ADDR_W + 1;
  localparam int D_W    = ADDR_W + 2;
  localparam int PGN_W  = A1_W - PSH;

  logic [ADDR_W-1:0] base_r  [NREG];
  logic [CNT_W-1:0]  pages_r [NREG];
  logic [1:0]        func_r;
  logic [CNT_W-1:0]  count_r;
  logic [REG_W-1:0]  reg_r;
  logic [WI_W-1:0]   w_r;
  logic [CNT_W-1:0]  run_r;
  logic [BM_W-1:0]   word_r;
  logic [2:0]        chunk_r;
  logic [PI_W-1:0]   end_r;
  logic [PI_W-1:0]   first_r;
  logic [WI_W-1:0]   mw_r;
  logic [A1_W-1:0]   a_r;
  logic [CNT_W-1:0]  rem_r;
  logic              pend_v_r;
  logic [AW-1:0]     pend_addr_r;
  logic [BM_W-1:0]   pmask_r;
  logic [ADDR_W-1:0] res_addr_r;
  logic              res_fail_r;
  logic              out_valid_r;
  bpra_pkg::out_word_t out_word_r;
  logic [DEPTH-1:0]  vld_r;
  logic              rvld_r;

  logic [NP_W-1:0]   nreg [NREG];
  logic [NP_W-1:0]   n_cur;
  logic [WI_W-1:0]   last_w;
  logic              word_last;
  logic [BM_W-1:0]   bmask;
  logic [BM_W-1:0]   rdata;
  logic [BM_W-1:0]   rword;
  logic [BM_W-1:0]   weff;
  logic [CNT_W:0]    run_p64;
  logic              free_hit;
  logic [5:0]        jf;
  bpra_pkg::ev_kind_t ev_kind;
  logic [7:0]        bits8;
  logic [CNT_W-1:0]  run_t;
  logic              ch_hit;
  logic [2:0]        jb;
  logic [D_W-1:0]    diff   [NREG];
  logic              in_rg  [NREG];
  logic [PI_W-1:0]   idx_rg [NREG];
  logic              pg_hit;
  logic [REG_W-1:0]  pg_reg;
  logic [PI_W-1:0]   pg_idx;
  logic [AW-1:0]     pg_addr;
  logic [5:0]        pg_bit;
  logic [WI_W-1:0]   first_w;
  logic [WI_W-1:0]   end_w;
  logic [5:0]        lo;
  logic [5:0]        hi;
  logic [BM_W-1:0]   amask;
  logic [CW-1:0]     first_wide;
  logic [PI_W-1:0]   first_nxt;
  logic              re;
  logic [AW-1:0]     raddr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [BM_W-1:0]   wdata;

  function automatic logic [AW-1:0] word_addr(input logic [REG_W-1:0] r,
                                              input logic [WI_W-1:0]  w);
    return AW'(r) * AW'(WPR) + AW'(w);
  endfunction

  function automatic logic [NP_W-1:0] n_of(input logic [CNT_W-1:0] p);
    logic [NP_W-1:0] pe;
    pe = NP_W'(p);
    return (pe > NP_W'(REGION_PAGES)) ? NP_W'(REGION_PAGES) : pe;
  endfunction

  // Scan of the current word.
  always_comb begin
    for (int r = 0; r < NREG; r++) begin
      nreg[r] = n_of(pages_r[r]);
    end
  end

  assign n_cur     = nreg[reg_r];
  assign last_w    = WI_W'((n_cur - NP_W'(1)) >> 6);
  assign word_last = (w_r == last_w);
  assign bmask     = (word_last && (n_cur[5:0] != 6'd0)) ? ({BM_W{1'b1}} << n_cur[5:0])
                                                          : '0;
  assign rword     = rvld_r ? rdata : '0;
  assign weff      = rword | bmask;
  assign run_p64   = {1'b0, run_r} + (CNT_W + 1)'(BM_W);
  assign free_hit  = (run_p64 >= {1'b0, count_r});
  assign jf        = 6'(count_r - run_r - CNT_W'(1));

  always_comb begin
    if (&weff) begin
      ev_kind = bpra_pkg::EV_FULL;
    end else if (~|weff) begin
      ev_kind = free_hit ? bpra_pkg::EV_FREE_HIT : bpra_pkg::EV_FREE_PASS;
    end else begin
      ev_kind = bpra_pkg::EV_MIXED;
    end
  end

  // Eight pages of a mixed word per cycle.
  assign bits8 = word_r[{chunk_r, 3'b000} +: 8];

  always_comb begin
    run_t  = run_r;
    ch_hit = 1'b0;
    jb     = '0;
    for (int b = 0; b < 8; b++) begin
      if (!ch_hit) begin
        if (bits8[b]) begin
          run_t = '0;
        end else begin
          run_t = run_t + CNT_W'(1);
        end
        if (run_t == count_r) begin
          ch_hit = 1'b1;
          jb     = 3'(b);
        end
      end
    end
  end

  // Region lookup of the page being marked; the lowest region wins.
  always_comb begin
    for (int r = 0; r < NREG; r++) begin
      diff[r]   = {1'b0, a_r} - {2'b00, base_r[r]};
      in_rg[r]  = !diff[r][D_W-1] && (diff[r][A1_W-1:PSH] < PGN_W'(nreg[r]));
      idx_rg[r] = diff[r][PSH +: PI_W];
    end
  end

  always_comb begin
    pg_hit = 1'b0;
    pg_reg = '0;
    pg_idx = '0;
    for (int r = NREG - 1; r >= 0; r--) begin
      if (in_rg[r]) begin
        pg_hit = 1'b1;
        pg_reg = REG_W'(r);
        pg_idx = idx_rg[r];
      end
    end
  end

  assign pg_addr = word_addr(pg_reg, WI_W'(pg_idx >> 6));
  assign pg_bit  = pg_idx[5:0];

  // Marking of an allocated run.
  assign first_w    = WI_W'(first_r >> 6);
  assign end_w      = WI_W'(end_r >> 6);
  assign lo         = (mw_r == first_w) ? first_r[5:0] : 6'd0;
  assign hi         = (mw_r == end_w) ? end_r[5:0] : 6'd63;
  assign amask      = ({BM_W{1'b1}} << lo) & ({BM_W{1'b1}} >> (6'd63 - hi));
  assign first_wide = CW'(end_r) + CW'(1) - CW'(count_r);
  assign first_nxt  = PI_W'(first_wide);

  // Bitmap port selection.
  assign re = cmd.rd_first | cmd.rd_next | cmd.am_rd | cmd.fl_rd;

  always_comb begin
    if (cmd.fl_rd) begin
      raddr = pend_addr_r;
    end else if (cmd.am_rd) begin
      raddr = word_addr(reg_r, mw_r);
    end else if (cmd.rd_next) begin
      raddr = word_addr(reg_r, w_r + WI_W'(1));
    end else begin
      raddr = word_addr(reg_r, '0);
    end
  end

  assign we    = cmd.am_wr | cmd.fl_wr;
  assign waddr = cmd.fl_wr ? pend_addr_r : word_addr(reg_r, mw_r);

  always_comb begin
    if (cmd.fl_wr) begin
      wdata = (func_r == bpra_pkg::FUNC_MARK) ? (rword | pmask_r) : (rword & ~pmask_r);
    end else begin
      wdata = rword | amask;
    end
  end

  bpra_ram #(
    .WIDTH (BM_W),
    .DEPTH (DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Control state and region registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < NREG; r++) begin
        base_r[r]  <= '0;
        pages_r[r] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (bpra_pkg::cfg_reg_t'(cfg_index))
          bpra_pkg::CFG_BASE_0:  base_r[0]  <= cfg_data;
          bpra_pkg::CFG_PAGES_0: pages_r[0] <= cfg_data[CNT_W-1:0];
          bpra_pkg::CFG_BASE_1:  base_r[1]  <= cfg_data;
          bpra_pkg::CFG_PAGES_1: pages_r[1] <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (cmd.take || cmd.fl_wr) begin
        pend_v_r <= 1'b0;
      end else if (cmd.mk_step && pg_hit) begin
        pend_v_r <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (re) begin
      rvld_r <= vld_r[raddr];
    end
    if (cmd.take) begin
      func_r     <= in_word.func;
      count_r    <= in_word.page_count;
      a_r        <= {1'b0, in_word.start_address};
      rem_r      <= in_word.page_count;
      reg_r      <= '0;
      run_r      <= '0;
      w_r        <= '0;
      res_addr_r <= '0;
      res_fail_r <= 1'b0;
    end
    if (cmd.set_fail) begin
      res_fail_r <= 1'b1;
    end
    if (cmd.rd_next) begin
      w_r <= w_r + WI_W'(1);
    end
    if (cmd.ev_step) begin
      unique case (ev_kind)
        bpra_pkg::EV_FULL:      run_r <= '0;
        bpra_pkg::EV_FREE_PASS: run_r <= run_p64[CNT_W-1:0];
        bpra_pkg::EV_FREE_HIT:  end_r <= PI_W'({w_r, jf});
        bpra_pkg::EV_MIXED: begin
          word_r  <= weff;
          chunk_r <= '0;
        end
        default: ;
      endcase
    end
    if (cmd.ch_step) begin
      run_r   <= run_t;
      chunk_r <= chunk_r + 3'd1;
      if (ch_hit) begin
        end_r <= PI_W'({w_r, chunk_r, jb});
      end
    end
    if (cmd.next_reg) begin
      reg_r <= reg_r + REG_W'(1);
      run_r <= '0;
      w_r   <= '0;
    end
    if (cmd.hit_setup) begin
      first_r <= first_nxt;
      mw_r    <= WI_W'(first_nxt >> 6);
    end
    if (cmd.am_rd) begin
      res_addr_r <= base_r[reg_r] + (ADDR_W'(first_r) << PSH);
    end
    if (cmd.mw_next) begin
      mw_r <= mw_r + WI_W'(1);
    end
    if (cmd.mk_step) begin
      a_r   <= a_r + A1_W'(bpra_pkg::PAGE_BYTES);
      rem_r <= rem_r - CNT_W'(1);
      if (pg_hit) begin
        if (pend_v_r) begin
          pmask_r <= pmask_r | (BM_W'(1) << pg_bit);
        end else begin
          pend_addr_r <= pg_addr;
          pmask_r     <= BM_W'(1) << pg_bit;
        end
      end
    end
    if (cmd.load_out) begin
      out_word_r <= '{run_address: res_addr_r, failed: res_fail_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign stat.func       = func_r;
  assign stat.cnt_zero   = (count_r == '0);
  assign stat.reg_empty  = (n_cur == '0);
  assign stat.reg_last   = (reg_r == REG_W'(NREG - 1));
  assign stat.ev_kind    = ev_kind;
  assign stat.word_last  = word_last;
  assign stat.ch_hit     = ch_hit;
  assign stat.chunk_last = (chunk_r == 3'd7);
  assign stat.am_last    = (mw_r == end_w);
  assign stat.rem_zero   = (rem_r == '0);
  assign stat.pg_hit     = pg_hit;
  assign stat.pend_v     = pend_v_r;
  assign stat.pend_same  = (pend_addr_r == pg_addr);
  assign stat.out_busy   = out_valid_r & ~out_ready;

endmodule

### rtl/bitmap_page_run_allocator_unit.sv
// Top level of the bitmap page run allocator.
//
// Requests arrive as words on the in_ channel (valid/ready): allocate a run of
// page_count 4 KiB pages, or mark or free every page of a byte range. Each
// request gives exactly one word on the out_ channel with the run address and
// the failure flag. Region bases and page counts are written over the cfg_
// channel, which is always ready; the user must see that it is written only
// while the block is idle, as the block does not enforce this. One request is
// handled at a time. An allocation is decoded, then each region is opened and
// its bitmap words are read in turn: a wholly used or wholly free word is
// judged whole and a mixed word is searched eight pages at a time; a run that
// is found is marked by a read and a write of every bitmap word it covers. A
// mark or free request is decoded, then steps through its pages and gathers
// the pages of one bitmap word into a mask; the word is read and written back
// when the step reaches another word or the range ends. Every request then
// loads the output register, from which the word is offered in the next
// cycle. The next request is accepted once the result is in the register,
// even while the receiver stalls; a further result waits until the register
// is taken. Reset clears the region registers and the valid bits of the bitmap,
// so every page is free straight after reset without a clearing pass.
module bitmap_page_run_allocator_unit #(
  parameter int REGION_PAGES = bpra_pkg::REGION_PAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bpra_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bpra_pkg::out_word_t             out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bpra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpra_pkg::CFG_DATA_W-1:0] cfg_data
);

  bpra_pkg::ctrl_cmd_t cmd;
  bpra_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  bpra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpra_dp #(
    .REGION_PAGES (REGION_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

### tb/tb_bitmap_page_run_allocator_unit.sv
// Self-checking testbench of the bitmap page run allocator with its own first-fit page model.
`timescale 1ns / 100ps

module tb_bitmap_page_run_allocator_unit;

  localparam int FUNC_W           = bpra_pkg::FUNC_W;
  localparam int ADDR_W           = bpra_pkg::ADDR_W;
  localparam int CNT_W            = bpra_pkg::CNT_W;
  localparam int NUM_REGIONS      = bpra_pkg::NUM_REGIONS;
  localparam int REGION_PAGES_DEF = bpra_pkg::REGION_PAGES_DEF;
  localparam int PAGE_SHIFT       = bpra_pkg::PAGE_SHIFT;
  localparam int PAGE_BYTES       = bpra_pkg::PAGE_BYTES;
  localparam int CFG_IDX_W        = bpra_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W       = bpra_pkg::CFG_DATA_W;

  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam logic [ADDR_W-1:0] TOP_PAGE   = 48'hFFFF_FFFF_F000;
  localparam logic [ADDR_W-1:0] ADDR_ONES  = 48'hFFFF_FFFF_FFFF;
  localparam logic [CNT_W-1:0]  CNT_ONES   = 13'h1FFF;
  localparam int DIRECTED_ROWS   = 25;
  localparam int FIRST_SET_ROW   = 5;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 88;
  localparam int QUIET_LIMIT     = 40000;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] start;
    logic [CNT_W-1:0]  count;
    bit                typed;
    logic [ADDR_W-1:0] run_address;
    logic              failed;
  } probe_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base0;
    logic [CNT_W-1:0]  pages0;
    logic [ADDR_W-1:0] base1;
    logic [CNT_W-1:0]  pages1;
  } region_plan_t;

  typedef struct {
    logic [ADDR_W-1:0] first_page;
    logic [CNT_W-1:0]  pages;
  } held_run_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  bpra_pkg::in_word_t    in_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  bpra_pkg::out_word_t   out_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [REGION_PAGES_DEF-1:0] page_busy [NUM_REGIONS];
  logic [ADDR_W-1:0]           region_base_q [NUM_REGIONS];
  logic [CNT_W-1:0]            region_pages_q [NUM_REGIONS];
  held_run_t                   held_runs [$];
  bpra_pkg::out_word_t         pending_grants [$];
  bpra_pkg::out_word_t         oldest_grant;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int bad_grants = 0;
  int grants_checked = 0;
  int requests = 0;
  int alloc_requests = 0;
  int alloc_refusals = 0;
  int quiet_cycles = 0;

  bitmap_page_run_allocator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned usable_pages(input int r);
    if (region_pages_q[r] > REGION_PAGES_DEF) return REGION_PAGES_DEF;
    return int'(region_pages_q[r]);
  endfunction

  function automatic bit grab_run(input int unsigned want, output logic [ADDR_W-1:0] where);
    int unsigned n, run, first, i, k;
    int r;
    logic [63:0] a;
    where = '0;
    if (want == 0) return 1'b0;
    for (r = 0; r < NUM_REGIONS; r++) begin
      n = usable_pages(r);
      run = 0;
      for (i = 0; i < n; i++) begin
        if (page_busy[r][i]) begin
          run = 0;
        end else begin
          run++;
          if (run == want) begin
            first = i + 1 - want;
            for (k = first; k <= i; k++) page_busy[r][k] = 1'b1;
            a = {16'b0, region_base_q[r]} + (64'(first) << PAGE_SHIFT);
            where = a[ADDR_W-1:0];
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void touch_range(input logic [ADDR_W-1:0] start, input int unsigned cnt,
                                      input bit used);
    int unsigned k;
    int r;
    logic [63:0] a, base, off;
    for (k = 0; k < cnt; k++) begin
      a = {16'b0, start} + (64'(k) << PAGE_SHIFT);
      for (r = 0; r < NUM_REGIONS; r++) begin
        base = {16'b0, region_base_q[r]};
        off = a - base;
        if (a >= base && off < (64'(usable_pages(r)) << PAGE_SHIFT)) begin
          page_busy[r][int'(off >> PAGE_SHIFT)] = used;
          break;
        end
      end
    end
  endfunction

  function automatic bpra_pkg::out_word_t serve_request(input bpra_pkg::in_word_t w);
    bpra_pkg::out_word_t g;
    logic [ADDR_W-1:0] where;
    g = '0;
    case (w.func)
      bpra_pkg::FUNC_ALLOC: begin
        alloc_requests++;
        if (grab_run(int'(w.page_count), where)) begin
          g.run_address = where;
          held_runs.push_back('{where, w.page_count});
        end else begin
          g.failed = 1'b1;
          alloc_refusals++;
        end
      end
      bpra_pkg::FUNC_MARK: touch_range(w.start_address, int'(w.page_count), 1'b1);
      bpra_pkg::FUNC_FREE: touch_range(w.start_address, int'(w.page_count), 1'b0);
      default: ;
    endcase
    return g;
  endfunction

  function automatic region_plan_t region_plan(input int plan);
    case (plan)
      0: return '{48'h0000_0010_0000, 13'd16, TOP_PAGE, CNT_ONES};
      1: return '{48'h0, 13'd4096, 48'h0000_0100_0000, 13'd4096};
      2: return '{48'h0000_4000_0000, 13'd20, 48'h0000_4000_A000, 13'd37};
      3: return '{TOP_PAGE, 13'd0, 48'h0007_0000_0000, 13'd130};
      4: return '{48'h8000_0000_0000, 13'd1, TOP_PAGE, 13'd4096};
      default: return '{48'h0000_1234_5000, 13'd100, 48'h0000_1238_5000, 13'd64};
    endcase
  endfunction

  function automatic probe_t directed_row(input int i);
    case (i)
      0:  return '{bpra_pkg::FUNC_ALLOC, 48'h0, 13'd1, 1'b1, 48'h0, 1'b1};
      1:  return '{bpra_pkg::FUNC_ALLOC, 48'h0, 13'd0, 1'b1, 48'h0, 1'b1};
      2:  return '{bpra_pkg::FUNC_MARK, 48'h0, CNT_ONES, 1'b1, 48'h0, 1'b0};
      3:  return '{FUNC_SPARE, ADDR_ONES, CNT_ONES, 1'b1, 48'h0, 1'b0};
      4:  return '{bpra_pkg::FUNC_FREE, ADDR_ONES, 13'd1, 1'b1, 48'h0, 1'b0};
      5:  return '{bpra_pkg::FUNC_ALLOC, 48'h0, 13'd0, 1'b1, 48'h0, 1'b1};
      6:  return '{bpra_pkg::FUNC_ALLOC, 48'h0, 13'd1, 1'b1, 48'h0000_0010_0000, 1'b0};
      7:  return '{bpra_pkg::FUNC_ALLOC, 48'h0, 13'd4, 1'b1, 48'h0000_0010_1000, 1'b0};
      8:  return '{bpra_pkg::FUNC_ALLOC, 48'h0, 13'd11, 1'b1, 48'h0000_0010_5000, 1'b0};
      9:  return '{bpra_pkg::FUNC_ALLOC, 48'h0, 13'd1, 1'b1, TOP_PAGE, 1'b0};
      10: return '{bpra_pkg::FUNC_ALLOC, 48'h0, 13'd2, 1'b1, 48'h0, 1'b0};
      11: return '{bpra_pkg::FUNC_ALLOC, 48'h0, 13'd4096, 1'b1, 48'h0, 1'b1};
      12: return '{bpra_pkg::FUNC_FREE, 48'h0000_0010_2800, 13'd3, 1'b1, 48'h0, 1'b0};
      13: return '{bpra_pkg::FUNC_ALLOC, 48'h0, 13'd3, 1'b0, 48'h0, 1'b0};
      14: return '{bpra_pkg::FUNC_MARK, 48'h0000_000F_F000, 13'd3, 1'b0, 48'h0, 1'b0};
      15: return '{bpra_pkg::FUNC_FREE, 48'h0000_0010_0000, CNT_ONES, 1'b0, 48'h0, 1'b0};
      16: return '{bpra_pkg::FUNC_ALLOC, 48'h0, 13'd16, 1'b0, 48'h0, 1'b0};
      17: return '{bpra_pkg::FUNC_ALLOC, 48'h0, 13'd17, 1'b0, 48'h0, 1'b0};
      18: return '{bpra_pkg::FUNC_FREE, TOP_PAGE, 13'd4096, 1'b0, 48'h0, 1'b0};
      19: return '{bpra_pkg::FUNC_ALLOC, 48'h0, 13'd4096, 1'b0, 48'h0, 1'b0};
      20: return '{FUNC_SPARE, 48'h0, 13'd0, 1'b1, 48'h0, 1'b0};
      21: return '{bpra_pkg::FUNC_FREE, 48'h0, 13'd0, 1'b1, 48'h0, 1'b0};
      22: return '{bpra_pkg::FUNC_ALLOC, 48'h0, CNT_ONES, 1'b1, 48'h0, 1'b1};
      23: return '{bpra_pkg::FUNC_FREE, TOP_PAGE, 13'd4096, 1'b0, 48'h0, 1'b0};
      default: return '{bpra_pkg::FUNC_FREE, 48'h0000_0010_0000, 13'd16, 1'b0, 48'h0, 1'b0};
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 88) return CNT_W'($urandom_range(1, 8));
    if (roll < 97) return CNT_W'($urandom_range(0, 80));
    if (roll == 97) return CNT_W'(REGION_PAGES_DEF);
    if (roll == 98) return CNT_ONES;
    return CNT_W'($urandom);
  endfunction

  function automatic bpra_pkg::in_word_t make_request();
    bpra_pkg::in_word_t w;
    int unsigned roll, pick;
    int r;
    logic [63:0] a;
    roll = $urandom_range(99);
    a = {$urandom, $urandom};
    w.func = bpra_pkg::FUNC_ALLOC;
    w.start_address = '0;
    w.page_count = pick_count();
    if (roll < 45) begin
      if ($urandom_range(3) == 0) w.start_address = a[ADDR_W-1:0];
    end else if (roll < 72 && held_runs.size() != 0) begin
      pick = $urandom_range(held_runs.size() - 1);
      a = {16'b0, held_runs[pick].first_page};
      if ($urandom_range(1) == 0) a = a + 64'($urandom_range(PAGE_BYTES - 1));
      w.func = bpra_pkg::FUNC_FREE;
      w.start_address = a[ADDR_W-1:0];
      w.page_count = held_runs[pick].pages;
      held_runs.delete(pick);
    end else if (roll < 92) begin
      r = $urandom_range(NUM_REGIONS - 1);
      a = {16'b0, region_base_q[r]} + (64'($urandom_range(usable_pages(r) + 1)) << PAGE_SHIFT);
      if ($urandom_range(7) == 0) a = a - (64'($urandom_range(1, 3)) << PAGE_SHIFT);
      if ($urandom_range(3) == 0) a = a + 64'($urandom_range(PAGE_BYTES - 1));
      w.func = ($urandom_range(2) == 0) ? bpra_pkg::FUNC_MARK : bpra_pkg::FUNC_FREE;
      w.start_address = a[ADDR_W-1:0];
    end else if (roll < 96) begin
      w.func = FUNC_W'($urandom_range(3));
      w.start_address = a[ADDR_W-1:0];
    end else begin
      w.func = FUNC_SPARE;
      w.start_address = a[ADDR_W-1:0];
    end
    return w;
  endfunction

  task automatic put_request(input bpra_pkg::in_word_t w, input bit typed,
                             input bpra_pkg::out_word_t typed_grant);
    bpra_pkg::out_word_t g;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    g = serve_request(w);
    pending_grants.push_back(typed ? typed_grant : g);
    requests++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input bpra_pkg::cfg_reg_t which,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (which)
      bpra_pkg::CFG_BASE_0:  region_base_q[0]  = data[ADDR_W-1:0];
      bpra_pkg::CFG_PAGES_0: region_pages_q[0] = data[CNT_W-1:0];
      bpra_pkg::CFG_BASE_1:  region_base_q[1]  = data[ADDR_W-1:0];
      bpra_pkg::CFG_PAGES_1: region_pages_q[1] = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input int plan);
    region_plan_t s;
    s = region_plan(plan);
    wait_idle();
    write_reg(bpra_pkg::CFG_BASE_0, s.base0);
    write_reg(bpra_pkg::CFG_PAGES_0, CFG_DATA_W'(s.pages0));
    write_reg(bpra_pkg::CFG_BASE_1, s.base1);
    write_reg(bpra_pkg::CFG_PAGES_1, CFG_DATA_W'(s.pages1));
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected result word: run_address %h failed %b",
               out_word.run_address, out_word.failed);
        bad_grants++;
      end else begin
        oldest_grant = pending_grants.pop_front();
        if (out_word.run_address !== oldest_grant.run_address) begin
          $error("run_address: expected %h, got %h", oldest_grant.run_address,
                 out_word.run_address);
          bad_grants++;
        end
        if (out_word.failed !== oldest_grant.failed) begin
          $error("failed: expected %b, got %b", oldest_grant.failed, out_word.failed);
          bad_grants++;
        end
        grants_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out: no word moved for %0d cycles.", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    int i, p, n;
    probe_t row;
    bpra_pkg::in_word_t w;
    bpra_pkg::out_word_t g;
    for (i = 0; i < NUM_REGIONS; i++) begin
      page_busy[i]      = '0;
      region_base_q[i]  = '0;
      region_pages_q[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      if (i == FIRST_SET_ROW) load_settings(0);
      row = directed_row(i);
      w.func          = row.func;
      w.start_address = row.start;
      w.page_count    = row.count;
      g.run_address   = row.run_address;
      g.failed        = row.failed;
      put_request(w, row.typed, g);
    end

    for (p = 0; p < PHASES; p++) begin
      load_settings(p);
      case (p % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 76;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 76;
        end
        default: begin
          tx_idle_pct  = 36;
          rx_stall_pct = 36;
        end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 2 && n == ITEMS_PER_PHASE / 2) wait_idle();
        put_request(make_request(), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (16) @(posedge clk);
    $display("Sent %0d requests, %0d allocations of which %0d found no run; %0d words checked.",
             requests, alloc_requests, alloc_refusals, grants_checked);
    $display("Region layouts ranged over disabled, saturated, overlapping and top-of-space.");
    if (bad_grants == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### bitmap_page_run_allocator_unit.f
rtl/bpra_pkg.sv
rtl/bpra_ram.sv
rtl/bpra_ctrl.sv
rtl/bpra_dp.sv
rtl/bitmap_page_run_allocator_unit.sv
tb/tb_bitmap_page_run_allocator_unit.sv
